FILE: rtl/mdfe_pkg.sv
package mdfe_pkg;

  // Codes for the kind field of a result transfer.
  typedef enum logic [1:0] {
    KIND_BODY = 2'd0,
    KIND_END  = 2'd1,
    KIND_DROP = 2'd2
  } kind_t;

  // Register indexes on the configuration port (paddr[3:2]).
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_MAX_BODY_LEN = 2'd2
  } reg_idx_t;

  localparam int LEN_W = 11;

  // Hard cap on the body length, whatever max_body_len holds.
  localparam logic [LEN_W-1:0] MAX_FRAME = 11'd1024;

  localparam logic [31:0]      START_MARKER_RESET = 32'h5F8A_BBCD;
  localparam logic [31:0]      END_MARKER_RESET   = 32'hB25E_38A2;
  localparam logic [LEN_W-1:0] MAX_BODY_LEN_RESET = 11'd1024;

  // Register file contents handed to the datapath.
  typedef struct packed {
    logic [31:0]      start_marker;
    logic [31:0]      end_marker;
    logic [LEN_W-1:0] max_body_len;
  } cfg_t;

endpackage

FILE: rtl/marker_delimited_frame_extractor_top.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   in_rx_byte[7:0]
// result    out        out_valid/out_stall out_kind[1:0], out_body_byte[7:0],
//                                          out_first_of_frame, out_body_length[10:0]
// config    APB        psel/penable/pready paddr[3:0], pwdata/prdata[31:0]
//
// Bytes are taken at one per cycle while no stall holds the flow: a transfer is
// registered in the input stage and moves through the deframer into the result
// register, so a new byte can enter while the previous one is in the deframer.
// The path between the input register and the result register holds the single
// window shift and the two 32-bit marker compares.
// rst_n is synchronous and active low; it returns the block to hunting and
// loads the marker and length registers with their defaults.
// A stall on the result side backs up into in_stall in the same cycle, but
// only when the input stage is occupied, so no transfer is lost or repeated.
module marker_delimited_frame_extractor_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_body_byte,
  output logic        out_first_of_frame,
  output logic [10:0] out_body_length,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mdfe_pkg::*;

  cfg_t cfg;

  mdfe_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage: holds one accepted byte until the deframer can consume it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Deframer state.
  logic [31:0]      window_r,  window_nxt;
  logic [2:0]       fill_r,    fill_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] count_r,   count_nxt;

  // Result register.
  logic             out_valid_r;
  kind_t            out_kind_r;
  logic [7:0]       out_byte_r;
  logic             out_first_r;
  logic [LEN_W-1:0] out_len_r;

  logic out_free;
  logic advance;
  logic in_take;

  // The result register can take a new value when it is empty or when its
  // current transfer completes in this cycle.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Deframer: one byte per pass, shift into the window, then compare.
  logic [31:0]      win;
  logic [2:0]       fill_inc;
  logic [LEN_W-1:0] limit;
  logic             res_valid;
  kind_t            res_kind;
  logic [7:0]       res_byte;
  logic             res_first;
  logic [LEN_W-1:0] res_len;

  assign win      = {window_r[23:0], s1_byte_r};
  assign fill_inc = (fill_r < 3'd4) ? fill_r + 3'd1 : 3'd4;
  assign limit    = (cfg.max_body_len > MAX_FRAME) ? MAX_FRAME : cfg.max_body_len;

  always_comb begin
    window_nxt   = win;
    fill_nxt     = fill_inc;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    res_valid    = 1'b0;
    res_kind     = KIND_BODY;
    res_byte     = 8'd0;
    res_first    = 1'b0;
    res_len      = '0;
    if (!in_frame_r) begin
      // Hunting: a start marker needs four fresh bytes in the window.
      if (fill_inc == 3'd4 && win == cfg.start_marker) begin
        window_nxt   = 32'd0;
        fill_nxt     = 3'd0;
        count_nxt    = '0;
        in_frame_nxt = 1'b1;
      end
    end else if (fill_inc == 3'd4) begin
      if (win == cfg.end_marker) begin
        // Good frame: report the length and go back to hunting.
        res_valid    = 1'b1;
        res_kind     = KIND_END;
        res_len      = count_r;
        window_nxt   = 32'd0;
        fill_nxt     = 3'd0;
        count_nxt    = '0;
        in_frame_nxt = 1'b0;
      end else if (count_r >= limit) begin
        // Body too long: the oldest byte is discarded and the frame dropped.
        res_valid    = 1'b1;
        res_kind     = KIND_DROP;
        window_nxt   = 32'd0;
        fill_nxt     = 3'd0;
        count_nxt    = '0;
        in_frame_nxt = 1'b0;
      end else begin
        // The oldest byte can no longer be part of the end marker.
        res_valid  = 1'b1;
        res_kind   = KIND_BODY;
        res_byte   = win[31:24];
        res_first  = (count_r == '0);
        window_nxt = {8'd0, win[23:0]};
        fill_nxt   = 3'd3;
        count_nxt  = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= 32'd0;
      fill_r     <= 3'd0;
      in_frame_r <= 1'b0;
      count_r    <= '0;
    end else if (advance) begin
      window_r   <= window_nxt;
      fill_r     <= fill_nxt;
      in_frame_r <= in_frame_nxt;
      count_r    <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_kind_r  <= res_kind;
      out_byte_r  <= res_byte;
      out_first_r <= res_first;
      out_len_r   <= res_len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_body_byte      = out_byte_r;
  assign out_first_of_frame = out_first_r;
  assign out_body_length    = out_len_r;

  // While hunting, a byte never produces a result transfer.
  a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !in_frame_r) |=> (out_valid_r == ($past(out_valid_r) && $past(out_stall))))
    else $error("result produced while hunting");

  // Inside a frame the window never rests with four bytes in it.
  a_fill_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_frame_r |-> (fill_r <= 3'd3))
    else $error("window fill out of range inside a frame");

  // The body count never passes the hard frame cap.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_FRAME)
    else $error("body count above frame cap");

  // End and drop results always return the deframer to hunting.
  a_end_hunts: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_valid && res_kind != KIND_BODY) |=> (!in_frame_r && fill_r == 3'd0))
    else $error("frame not closed after end or drop");

  // A result stays put while it is stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_kind_r) && $stable(out_len_r)))
    else $error("stalled result changed");

endmodule

FILE: rtl/mdfe_cfg_regs.sv
module mdfe_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mdfe_pkg::cfg_t cfg
);
  import mdfe_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= START_MARKER_RESET;
      cfg_r.end_marker   <= END_MARKER_RESET;
      cfg_r.max_body_len <= MAX_BODY_LEN_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_START_MARKER: cfg_r.start_marker <= pwdata;
        REG_END_MARKER:   cfg_r.end_marker   <= pwdata;
        REG_MAX_BODY_LEN: cfg_r.max_body_len <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_MARKER: prdata = cfg_r.start_marker;
      REG_END_MARKER:   prdata = cfg_r.end_marker;
      REG_MAX_BODY_LEN: prdata = {{(32-LEN_W){1'b0}}, cfg_r.max_body_len};
      default:          prdata = 32'd0;
    endcase
  end

endmodule
